>>> sv/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/aoae_pkg.sv
// shared types, widths and codes of the adc offset average engine
package aoae_pkg;

  localparam int CHANNELS_DEF    = 16;
  localparam int CAL_SAMPLES_DEF = 16;
  localparam int SAMPLE_BITS     = 10;

  localparam int CH_W    = 4;
  localparam int VAL_W   = 10;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 16;
  localparam int ACC_W   = 32;
  localparam int SUM_W   = 16;
  localparam int TDATA_W = 16;
  localparam int CFG_AW  = 2;

  localparam logic [VAL_W-1:0] SAMPLE_MASK = VAL_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [VAL_W-1:0] VALUE_MAX   = '1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BUSY = 2'd1,
    MODE_CAL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DATA = 2'd0,
    STAT_ACC  = 2'd1,
    STAT_REJ  = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CAL    = 2'd2
  } kind_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_AVG_EN  = 2'd0,
    REG_AVG_CNT = 2'd1,
    REG_CONT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ACC_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [VAL_W-1:0]  value;
    status_t           status;
    logic              done;
    logic              last;
  } res_t;

endpackage

>>> sv/adc_offset_average_engine.sv
// top level: adc batch post-processor with offset calibration and averaging
// usage:
// - input words on in_*: tuser selects start (0), sample (1) or calibrate (2);
//   tdata carries channel and raw sample, tlast marks the last sample of a batch
// - result words on out_*: tdata carries channel, value and done, tuser the
//   status (data, command accepted, command rejected), tlast the final word
// - config writes on cfg_* are taken any cycle, meant only while idle
// - a command or pass-through sample is first accepted, then the
//   accumulator memory read lands and the word goes to the output register
// - an averaged sample is a read-modify-write of the accumulator memory
// - at the final batch end the averages come out in channel order; each channel
//   is one memory read plus a 32-step division
// - the last calibration sample passes through an extra state for the reciprocal multiply
// - reset puts the block idle with zero offset and zero accumulators; the
//   accumulators use per-entry valid bits, so no clearing pass is needed
// - in_tready drops while a word is in process; an output word waits in the
//   output register while out_tready is low and a new input word may be taken,
//   but the next result then holds the block until the register frees up
module adc_offset_average_engine #(
  parameter int CHANNELS    = aoae_pkg::CHANNELS_DEF,
  parameter int CAL_SAMPLES = aoae_pkg::CAL_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // config write port
  input  logic                         cfg_we,
  input  logic [aoae_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [aoae_pkg::CNT_W-1:0]   cfg_wdata,
  // input words
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [aoae_pkg::TDATA_W-1:0] in_tdata,   // channel[3:0], sample[13:4], zero[15:14]
  input  logic [aoae_pkg::KIND_W-1:0]  in_tuser,   // kind[1:0]
  input  logic                         in_tlast,   // batch end
  // result words
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [aoae_pkg::TDATA_W-1:0] out_tdata,  // channel[3:0], value[13:4], done[14], zero[15]
  output logic [1:0]                   out_tuser,  // status[1:0]
  output logic                         out_tlast   // last
);
  import aoae_pkg::*;

  `include "assert_macros.svh"

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CAL_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
  // offset = cal_sum / CAL_SAMPLES by reciprocal multiply, exact for any 16-bit sum
  localparam int CAL_SH = SUM_W + 5;
  localparam logic [CAL_SH:0] CAL_RECIP =
    (CAL_SH+1)'(((64'd1 << CAL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_SWRD,
    ST_SWST,
    ST_SWDIV,
    ST_CALDIV
  } state_t;

  // control state
  state_t             st_r, st_nxt;
  mode_t              mode_r, mode_nxt;
  mode_t              saved_mode_r, saved_mode_nxt;
  logic [CNT_W-1:0]   batches_done_r, batches_done_nxt;
  logic [VAL_W-1:0]   offset_r, offset_nxt;
  logic [SUM_W-1:0]   cal_sum_r, cal_sum_nxt;
  logic [CAL_W-1:0]   cal_seen_r, cal_seen_nxt;
  logic               avg_en_r, avg_en_nxt;
  logic [CNT_W-1:0]   avg_cnt_r, avg_cnt_nxt;
  logic               cont_r, cont_nxt;
  logic               sweep_r, sweep_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [VAL_W-1:0]   smp_r, smp_nxt;
  logic               bend_r, bend_nxt;
  logic [AW-1:0]      chan_r, chan_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;

  // memory and divider hookup
  logic               mem_we, mem_re, mem_clr;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ACC_W-1:0]   mem_wdata, mem_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // scratch
  logic               accept;
  logic               emit_ok;
  logic               produce;
  res_t               res;
  res_t               res_sel;
  logic               in_range;
  logic [VAL_W-1:0]   corr;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   bd_inc;
  logic [SUM_W-1:0]   cal_sum_inc;
  logic [CAL_W-1:0]   cal_seen_inc;
  logic [SUM_W+CAL_SH:0] cal_prod;

  aoae_acc_ram #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_acc_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  aoae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign emit_ok   = !out_valid_r || out_tready;

  always_comb begin
    in_range     = ({1'b0, ch_r} < 5'(CHANNELS));
    corr         = (smp_r > offset_r) ? (smp_r - offset_r) : '0;
    cnt_eff      = (avg_cnt_r == '0) ? CNT_W'(1) : avg_cnt_r;
    bd_inc       = batches_done_r + CNT_W'(1);
    cal_sum_inc  = cal_sum_r + SUM_W'(smp_r);
    cal_seen_inc = cal_seen_r + CAL_W'(1);
    cal_prod     = {{(CAL_SH+1){1'b0}}, cal_sum_r} * {{SUM_W{1'b0}}, CAL_RECIP};
  end

  always_comb begin
    st_nxt           = st_r;
    mode_nxt         = mode_r;
    saved_mode_nxt   = saved_mode_r;
    batches_done_nxt = batches_done_r;
    offset_nxt       = offset_r;
    cal_sum_nxt      = cal_sum_r;
    cal_seen_nxt     = cal_seen_r;
    avg_en_nxt       = avg_en_r;
    avg_cnt_nxt      = avg_cnt_r;
    cont_nxt         = cont_r;
    sweep_nxt        = sweep_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    kind_nxt         = kind_r;
    ch_nxt           = ch_r;
    smp_nxt          = smp_r;
    bend_nxt         = bend_r;
    chan_nxt         = chan_r;
    res_nxt          = res_r;
    out_nxt          = out_r;

    mem_we           = 1'b0;
    mem_waddr        = ch_r[AW-1:0];
    mem_wdata        = mem_rdata + ACC_W'(corr);
    mem_re           = 1'b0;
    mem_raddr        = in_tdata[AW-1:0];
    mem_clr          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mem_rdata;
    div_req.divisor  = cnt_eff;

    produce          = 1'b0;
    res              = '0;
    res.status       = STAT_ACC;
    res.last         = 1'b1;

    // config writes
    if (cfg_we) begin
      case (cfg_addr)
        REG_AVG_EN:  avg_en_nxt  = cfg_wdata[0];
        REG_AVG_CNT: avg_cnt_nxt = cfg_wdata;
        REG_CONT:    cont_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_tuser;
          ch_nxt   = in_tdata[CH_W-1:0];
          smp_nxt  = in_tdata[CH_W +: VAL_W] & SAMPLE_MASK;
          bend_nxt = in_tlast;
          mem_re   = 1'b1;  // accumulator of this channel lands in exec
          st_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        st_nxt = ST_IDLE;
        case (kind_r)
          KIND_START: begin
            produce = 1'b1;
            if (mode_r == MODE_IDLE) begin
              mode_nxt = MODE_BUSY;
            end else begin
              res.status = STAT_REJ;
            end
          end
          KIND_CAL: begin
            produce = 1'b1;
            if (mode_r != MODE_CAL) begin
              saved_mode_nxt = mode_r;
              mode_nxt       = MODE_CAL;
              cal_sum_nxt    = '0;
              cal_seen_nxt   = '0;
            end else begin
              res.status = STAT_REJ;
            end
          end
          KIND_SAMPLE: begin
            case (mode_r)
              MODE_CAL: begin
                cal_sum_nxt  = cal_sum_inc;
                cal_seen_nxt = cal_seen_inc;
                if (cal_seen_inc >= CAL_W'(CAL_SAMPLES)) begin
                  st_nxt = ST_CALDIV;
                end
              end
              MODE_BUSY: begin
                if (!avg_en_r) begin
                  if (in_range) begin
                    produce     = 1'b1;
                    res.channel = ch_r;
                    res.value   = corr;
                    res.status  = STAT_DATA;
                    res.done    = bend_r;
                  end
                end else begin
                  mem_we = in_range;
                  if (bend_r) begin
                    if (bd_inc >= cnt_eff) begin
                      batches_done_nxt = '0;
                      chan_nxt         = '0;
                      sweep_nxt        = 1'b1;
                      st_nxt           = ST_SWRD;
                    end else begin
                      batches_done_nxt = bd_inc;
                    end
                  end
                end
                if (bend_r && !cont_r) begin
                  mode_nxt = MODE_IDLE;
                end
              end
              default: ;
            endcase
          end
          default: begin
            produce    = 1'b1;
            res.status = STAT_REJ;
          end
        endcase
      end

      // averaging sweep: read, divide, emit, one channel at a time
      ST_SWRD: begin
        mem_re    = 1'b1;
        mem_raddr = chan_r;
        st_nxt    = ST_SWST;
      end

      ST_SWST: begin
        div_req.start = 1'b1;
        st_nxt        = ST_SWDIV;
      end

      ST_SWDIV: begin
        if (div_rsp.done) begin
          produce     = 1'b1;
          res.channel = CH_W'(chan_r);
          res.value   = (|div_rsp.quotient[ACC_W-1:VAL_W]) ? VALUE_MAX
                                                          : div_rsp.quotient[VAL_W-1:0];
          res.status  = STAT_DATA;
          res.done    = (chan_r == LAST_CH);
          res.last    = (chan_r == LAST_CH);
        end
      end

      // full calibration sum is in cal_sum_r, scale it into the offset
      ST_CALDIV: begin
        offset_nxt   = cal_prod[CAL_SH +: VAL_W] & SAMPLE_MASK;
        mode_nxt     = saved_mode_r;
        cal_sum_nxt  = '0;
        cal_seen_nxt = '0;
        st_nxt       = ST_IDLE;
      end

      ST_EMIT: ;

      default: st_nxt = ST_IDLE;
    endcase

    // hand a result to the output register, or park it until the slot frees
    res_sel = (st_r == ST_EMIT) ? res_r : res;
    if (produce || st_r == ST_EMIT) begin
      if (emit_ok) begin
        out_nxt       = res_sel;
        out_valid_nxt = 1'b1;
        if (sweep_r) begin
          if (chan_r == LAST_CH) begin
            mem_clr   = 1'b1;
            sweep_nxt = 1'b0;
            st_nxt    = ST_IDLE;
          end else begin
            chan_nxt = chan_r + AW'(1);
            st_nxt   = ST_SWRD;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end else begin
        res_nxt = res_sel;
        st_nxt  = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    ch_r   <= ch_nxt;
    smp_r  <= smp_nxt;
    bend_r <= bend_nxt;
    chan_r <= chan_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      mode_r         <= MODE_IDLE;
      saved_mode_r   <= MODE_IDLE;
      batches_done_r <= '0;
      offset_r       <= '0;
      cal_sum_r      <= '0;
      cal_seen_r     <= '0;
      avg_en_r       <= 1'b0;
      avg_cnt_r      <= CNT_W'(1);
      cont_r         <= 1'b0;
      sweep_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      mode_r         <= mode_nxt;
      saved_mode_r   <= saved_mode_nxt;
      batches_done_r <= batches_done_nxt;
      offset_r       <= offset_nxt;
      cal_sum_r      <= cal_sum_nxt;
      cal_seen_r     <= cal_seen_nxt;
      avg_en_r       <= avg_en_nxt;
      avg_cnt_r      <= avg_cnt_nxt;
      cont_r         <= cont_nxt;
      sweep_r        <= sweep_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.done, out_r.value, out_r.channel};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

  `ASSERT_IMP(a_done_is_last, out_valid_r && out_r.done, out_r.last,
    "done word is not the last word of its input")
  `ASSERT_IMP(a_cmd_zero_payload, out_valid_r && out_r.status != STAT_DATA,
    out_r.channel == '0 && out_r.value == '0 && !out_r.done,
    "command response carries data")
  `ASSERT_IMP(a_saved_mode_not_cal, 1'b1, saved_mode_r != MODE_CAL,
    "saved mode is calibrating")
  `ASSERT_IMP(a_sweep_blocks_input, sweep_r, st_r != ST_IDLE,
    "input open during average sweep")

endmodule

>>> sv/aoae_acc_ram.sv
// per-channel accumulator memory, one write and one registered read port
module aoae_acc_ram #(
  parameter int DEPTH = aoae_pkg::CHANNELS_DEF,
  parameter int AW    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [aoae_pkg::ACC_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [aoae_pkg::ACC_W-1:0] rdata
);
  import aoae_pkg::*;

  logic [ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [ACC_W-1:0] rdata_r;
  logic             rvalid_r;

  // storage, no reset: entries count only once their valid bit is set
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

>>> sv/aoae_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module aoae_div (
  input  logic               clk,
  input  logic               rst_n,
  input  aoae_pkg::div_req_t req,
  output aoae_pkg::div_rsp_t rsp
);
  import aoae_pkg::*;

  localparam int STEP_W = $clog2(ACC_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [ACC_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  always_comb begin
    rem_shift = {rem_r, quo_r[ACC_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    fits      = (rem_shift >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[ACC_W-2:0], fits};
      rem_r <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      cnt_r <= cnt_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `ASSERT_IMP(a_start_when_free, req.start, !busy_r, "divider started while busy")
  `ASSERT_NXT(a_finish_step, busy_r && !req.start && cnt_r == LAST_STEP, done_r && !busy_r,
    "divider did not finish after last step")
  `ASSERT_NXT(a_done_single, done_r, !done_r, "divider done held for more than one cycle")

endmodule
